// ===== hw/rtl/mlfr_pkg.sv =====
// Shared types, widths and constants for the moving line falloff renderer.
// No dependencies; imported by every module of the block.
package mlfr_pkg;

  localparam int MAX_LEDS    = 1024;
  localparam int LEN_W       = $clog2(MAX_LEDS) + 1;
  localparam int IDX_W       = $clog2(MAX_LEDS);
  localparam int FRAME_W     = 16;
  localparam int START_W     = 11;
  localparam int SPEED_W     = 14;
  localparam int COL_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 14;

  localparam int FRAC_W      = 9;
  localparam int POS_W       = 32;
  localparam int PROD_W      = FRAME_W + 1 + SPEED_W;
  localparam int C_W         = POS_W - FRAC_W;
  localparam int CMAG_W      = 21;
  localparam int D_W         = FRAC_W + 1;

  localparam int DIV_STEP    = 3;
  localparam int DIV_CYCLES  = CMAG_W / DIV_STEP;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

  localparam int DIST_W      = 12;
  localparam int REM_W       = 11;
  localparam int SQ_W        = 2 * REM_W;
  localparam int CUBE_W      = 33;
  localparam int CUBE_SH     = 8;
  localparam int Y_W         = CUBE_W - CUBE_SH;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SH    = 34;
  localparam int PRODQ_W     = Y_W + RECIP_W;
  localparam int W_W         = 17;
  localparam int CPROD_W     = COL_W + W_W;
  localparam int WFRAC_W     = 16;

  localparam logic [DIST_W-1:0]  FALLOFF_SPAN = DIST_W'(1792);
  localparam logic [RECIP_W-1:0] RECIP_M      = RECIP_W'(50087082);
  localparam int                 DIV343       = 343;

  localparam int OUT_DEPTH   = 8;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int PIPE_STAGES = 6;
  localparam int NB_COUNT    = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_RED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_GREEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_BLUE    = 3'd5;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [START_W-1:0] start;
    logic [SPEED_W-1:0] speed;
    logic [COL_W-1:0]   red;
    logic [COL_W-1:0]   green;
    logic [COL_W-1:0]   blue;
  } cfg_t;

  typedef struct packed {
    logic             empty;
    logic [IDX_W-1:0] centre;
    logic [D_W-1:0]   d;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             lit;
    logic             last;
  } meta_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic             lit;
    logic             last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } div_st_t;

endpackage

// ===== hw/rtl/mlfr_front.sv =====
// Front end: frame intake, line position and wrap of the centre into the strip.
// Depends on mlfr_pkg; feeds mlfr_cmd_queue.
module mlfr_front import mlfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_push,
  output logic               in_full,
  input  logic [FRAME_W-1:0] in_frame_number,
  output logic               cmd_push,
  input  logic               cmd_full,
  output cmd_t               cmd
);

  logic                 hold_v_r, hold_v_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  div_st_t              st_r, st_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CMAG_W-1:0]    mag_r, mag_nxt;
  logic [IDX_W-1:0]     rem_r, rem_nxt;
  logic                 neg_r, neg_nxt;
  logic [D_W-1:0]       d_r, d_nxt;

  logic signed [PROD_W-1:0] prod;
  logic signed [POS_W-1:0]  pos;
  logic [POS_W-1:0]         pr;
  logic [C_W-1:0]           cabs;
  logic [D_W-1:0]           d_c;
  logic [LEN_W-1:0]         r;
  logic                     load;
  logic [IDX_W-1:0]         centre;
  logic [LEN_W:0]           centre_p2;

  assign in_full = hold_v_r;

  assign prod = $signed({1'b0, frame_r}) * $signed(cfg.speed);
  assign pos  = $signed({{(POS_W-START_W-FRAC_W){cfg.start[START_W-1]}}, cfg.start,
                         {FRAC_W{1'b0}}})
              + $signed({{(POS_W-PROD_W){prod[PROD_W-1]}}, prod});
  assign pr   = pos + POS_W'(1 << (FRAC_W - 1));
  assign cabs = pr[POS_W-1] ? (C_W'(0) - pr[POS_W-1:FRAC_W]) : pr[POS_W-1:FRAC_W];
  assign d_c  = D_W'(1 << (FRAC_W - 1)) - {1'b0, pr[FRAC_W-1:0]};

  assign load = hold_v_r && ((st_r == ST_IDLE) || ((st_r == ST_DONE) && !cmd_full));

  assign centre    = (neg_r && (rem_r != '0)) ? IDX_W'(cfg.len - {1'b0, rem_r}) : rem_r;
  assign centre_p2 = {2'b00, centre} + (LEN_W + 1)'(2);

  assign cmd_push   = (st_r == ST_DONE);
  assign cmd.empty  = !(centre_p2 < {1'b0, cfg.len});
  assign cmd.centre = centre;
  assign cmd.d      = d_r;

  always_comb begin
    r = {1'b0, rem_r};
    for (int i = 0; i < DIV_STEP; i++) begin
      r = {r[LEN_W-2:0], mag_r[CMAG_W-1-i]};
      if (r >= cfg.len) begin
        r = r - cfg.len;
      end
    end
  end

  always_comb begin
    hold_v_nxt = hold_v_r;
    frame_nxt  = frame_r;
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    mag_nxt    = mag_r;
    rem_nxt    = rem_r;
    neg_nxt    = neg_r;
    d_nxt      = d_r;
    case (st_r)
      ST_IDLE: begin
      end
      ST_DIV: begin
        mag_nxt = mag_r << DIV_STEP;
        rem_nxt = r[IDX_W-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!cmd_full) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    if (load) begin
      hold_v_nxt = 1'b0;
      st_nxt     = ST_DIV;
      cnt_nxt    = '0;
      mag_nxt    = cabs[CMAG_W-1:0];
      rem_nxt    = '0;
      neg_nxt    = pr[POS_W-1];
      d_nxt      = d_c;
    end
    if (in_push && !hold_v_r) begin
      hold_v_nxt = 1'b1;
      frame_nxt  = in_frame_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      st_r     <= ST_IDLE;
      cnt_r    <= '0;
    end else begin
      hold_v_r <= hold_v_nxt;
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
    end
    frame_r <= frame_nxt;
    mag_r   <= mag_nxt;
    rem_r   <= rem_nxt;
    neg_r   <= neg_nxt;
    d_r     <= d_nxt;
  end

endmodule

// ===== hw/rtl/mlfr_cmd_queue.sv =====
// Two-entry queue of classified frames between front end and back end.
// Depends on mlfr_pkg.
module mlfr_cmd_queue import mlfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  cmd_t wdata,
  output logic empty,
  input  logic pop,
  output cmd_t rdata
);

  cmd_t       mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r ^ do_push;
    rd_nxt  = rd_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/mlfr_back.sv =====
// Back end: walks the neighbours of a frame, computes cubic falloff and colours,
// and queues the results. Depends on mlfr_pkg; fed by mlfr_cmd_queue.
module mlfr_back import mlfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  input  cmd_t             cmd,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [IDX_W-1:0] out_led_index,
  output logic [COL_W-1:0] out_red_out,
  output logic [COL_W-1:0] out_green_out,
  output logic [COL_W-1:0] out_blue_out,
  output logic             out_lit,
  output logic             out_last_of_frame
);

  function automatic logic [2:0] nb_off(input logic [2:0] k);
    logic [2:0] o;
    case (k)
      3'd0:    o = 3'b000;
      3'd1:    o = 3'b001;
      3'd2:    o = 3'b010;
      3'd3:    o = 3'b011;
      3'd4:    o = 3'b111;
      3'd5:    o = 3'b110;
      3'd6:    o = 3'b101;
      default: o = 3'b000;
    endcase
    return o;
  endfunction

  logic                act_r, act_nxt;
  logic [NB_COUNT-1:0] mask_r, mask_nxt;
  logic [IDX_W-1:0]    centre_r, centre_nxt;
  logic [D_W-1:0]      d_r, d_nxt;
  logic                empty_r, empty_nxt;

  logic [NB_COUNT-1:0] sel;
  logic [2:0]          k;
  logic [2:0]          off;
  logic                last_k;
  logic                issue;
  logic                credit_ok;
  logic [NB_COUNT-1:0] load_mask;
  logic [DIST_W-1:0]   dd;
  logic [DIST_W-1:0]   dist_abs;
  logic [DIST_W-1:0]   dist_c;
  logic [REM_W-1:0]    rem_c;
  logic [LEN_W-1:0]    idx_sum;
  meta_t               meta_c;

  logic [PIPE_STAGES-1:0] vld_r;
  meta_t                  meta_r [PIPE_STAGES];
  logic [REM_W-1:0]       rem1_r, rem2_r;
  logic [SQ_W-1:0]        sq_r;
  logic [CUBE_W-1:0]      cube_r;
  logic [Y_W-1:0]         y_r;
  logic [W_W-1:0]         q0_r;
  logic [W_W-1:0]         w_r;
  logic [COL_W-1:0]       red_r, green_r, blue_r;

  logic [PRODQ_W-1:0]     prodq;
  logic [Y_W:0]           t343;
  logic [Y_W:0]           rr;
  logic [W_W-1:0]         w_nxt;
  logic [CPROD_W-1:0]     pr_red, pr_green, pr_blue;

  result_t                fifo_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [OUT_PTR_W:0]     cnt_r, cnt_nxt;
  logic                   do_pop;
  result_t                push_data;

  // lowest pending neighbour goes next
  assign sel    = mask_r & (~mask_r + 1'b1);
  assign last_k = ((mask_r & ~sel) == '0);

  always_comb begin
    k = '0;
    for (int j = 0; j < NB_COUNT; j++) begin
      if (sel[j]) begin
        k = 3'(j);
      end
    end
  end

  assign off       = nb_off(k);
  assign credit_ok = (({1'b0, cnt_r} + (OUT_PTR_W + 2)'($countones(vld_r)))
                      < (OUT_PTR_W + 2)'(OUT_DEPTH));
  assign issue     = act_r && credit_ok;
  assign cmd_pop   = !cmd_empty && (!act_r || (issue && last_k));

  assign load_mask = cmd.empty ? NB_COUNT'(1) :
                     {cmd.centre >= IDX_W'(3),
                      cmd.centre >= IDX_W'(2),
                      cmd.centre != '0,
                      ({2'b00, cmd.centre} + (LEN_W + 1)'(3)) != {1'b0, cfg.len},
                      3'b111};

  assign dd       = {{(DIST_W-D_W){d_r[D_W-1]}}, d_r} + {off, {FRAC_W{1'b0}}};
  assign dist_abs = dd[DIST_W-1] ? (DIST_W'(0) - dd) : dd;
  assign dist_c   = (dist_abs > FALLOFF_SPAN) ? FALLOFF_SPAN : dist_abs;
  assign rem_c    = REM_W'(FALLOFF_SPAN - dist_c);
  assign idx_sum  = {1'b0, centre_r} + {{(LEN_W-3){off[2]}}, off};

  always_comb begin
    meta_c.idx  = empty_r ? '0 : idx_sum[IDX_W-1:0];
    meta_c.lit  = !empty_r;
    meta_c.last = last_k;
  end

  always_comb begin
    act_nxt    = act_r;
    mask_nxt   = mask_r;
    centre_nxt = centre_r;
    d_nxt      = d_r;
    empty_nxt  = empty_r;
    if (issue) begin
      mask_nxt = mask_r & ~sel;
      if (last_k) begin
        act_nxt = 1'b0;
      end
    end
    if (cmd_pop) begin
      act_nxt    = 1'b1;
      mask_nxt   = load_mask;
      centre_nxt = cmd.centre;
      d_nxt      = cmd.d;
      empty_nxt  = cmd.empty;
    end
  end

  // weight = floor(rem^3 / (343 * 256)) through a reciprocal and one correction
  assign prodq    = PRODQ_W'(cube_r[CUBE_W-1:CUBE_SH]) * PRODQ_W'(RECIP_M);
  assign t343     = (Y_W + 1)'(q0_r) * (Y_W + 1)'(DIV343);
  assign rr       = {1'b0, y_r} - t343;
  assign w_nxt    = q0_r + W_W'(rr >= (Y_W + 1)'(DIV343));
  assign pr_red   = CPROD_W'(cfg.red) * CPROD_W'(w_r);
  assign pr_green = CPROD_W'(cfg.green) * CPROD_W'(w_r);
  assign pr_blue  = CPROD_W'(cfg.blue) * CPROD_W'(w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      vld_r <= '0;
    end else begin
      act_r <= act_nxt;
      vld_r <= {vld_r[PIPE_STAGES-2:0], issue};
    end
    mask_r    <= mask_nxt;
    centre_r  <= centre_nxt;
    d_r       <= d_nxt;
    empty_r   <= empty_nxt;
    meta_r[0] <= meta_c;
    for (int s = 1; s < PIPE_STAGES; s++) begin
      meta_r[s] <= meta_r[s-1];
    end
    rem1_r  <= rem_c;
    sq_r    <= SQ_W'(rem1_r) * SQ_W'(rem1_r);
    rem2_r  <= rem1_r;
    cube_r  <= CUBE_W'(sq_r) * CUBE_W'(rem2_r);
    y_r     <= cube_r[CUBE_W-1:CUBE_SH];
    q0_r    <= prodq[RECIP_SH +: W_W];
    w_r     <= w_nxt;
    red_r   <= meta_r[4].lit ? pr_red[WFRAC_W +: COL_W] : '0;
    green_r <= meta_r[4].lit ? pr_green[WFRAC_W +: COL_W] : '0;
    blue_r  <= meta_r[4].lit ? pr_blue[WFRAC_W +: COL_W] : '0;
  end

  // result queue
  assign do_pop = out_pop && (cnt_r != '0);

  always_comb begin
    push_data.idx   = meta_r[PIPE_STAGES-1].idx;
    push_data.red   = red_r;
    push_data.green = green_r;
    push_data.blue  = blue_r;
    push_data.lit   = meta_r[PIPE_STAGES-1].lit;
    push_data.last  = meta_r[PIPE_STAGES-1].last;
    wr_nxt  = wr_r + OUT_PTR_W'(vld_r[PIPE_STAGES-1]);
    rd_nxt  = rd_r + OUT_PTR_W'(do_pop);
    cnt_nxt = cnt_r + (OUT_PTR_W + 1)'(vld_r[PIPE_STAGES-1]) - (OUT_PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (vld_r[PIPE_STAGES-1]) begin
      fifo_r[wr_r] <= push_data;
    end
  end

  assign out_empty         = (cnt_r == '0);
  assign out_led_index     = fifo_r[rd_r].idx;
  assign out_red_out       = fifo_r[rd_r].red;
  assign out_green_out     = fifo_r[rd_r].green;
  assign out_blue_out      = fifo_r[rd_r].blue;
  assign out_lit           = fifo_r[rd_r].lit;
  assign out_last_of_frame = fifo_r[rd_r].last;

endmodule

// ===== hw/rtl/moving_line_falloff_renderer_core.sv =====
// Moving line falloff renderer: configuration registers, front end, command
// queue and back end. Depends on mlfr_pkg, mlfr_front, mlfr_cmd_queue, mlfr_back.
// Frame rate is set by the position modulo unit (3 quotient bits per cycle over 21 bits,
//   plus handoff to the command queue); it holds one further frame while it works.
//   Results leave one per cycle while out_pop is held and the result queue is not empty.
// Reset: synchronous, active low; registers take their defaults, all queues empty.
module moving_line_falloff_renderer_core import mlfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [FRAME_W-1:0]    in_frame_number,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [IDX_W-1:0]      out_led_index,
  output logic [COL_W-1:0]      out_red_out,
  output logic [COL_W-1:0]      out_green_out,
  output logic [COL_W-1:0]      out_blue_out,
  output logic                  out_lit,
  output logic                  out_last_of_frame,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [COL_W-1:0]   red_r, red_nxt;
  logic [COL_W-1:0]   green_r, green_nxt;
  logic [COL_W-1:0]   blue_r, blue_nxt;
  cfg_t               cfg;
  logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t               cmd_w, cmd_r;

  always_comb begin
    len_nxt   = len_r;
    start_nxt = start_r;
    speed_nxt = speed_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_STRIP_LENGTH: len_nxt   = cfg_wdata[LEN_W-1:0];
        CFG_START_OFFSET: start_nxt = cfg_wdata[START_W-1:0];
        CFG_SPEED_STEP:   speed_nxt = cfg_wdata[SPEED_W-1:0];
        CFG_BASE_RED:     red_nxt   = cfg_wdata[COL_W-1:0];
        CFG_BASE_GREEN:   green_nxt = cfg_wdata[COL_W-1:0];
        CFG_BASE_BLUE:    blue_nxt  = cfg_wdata[COL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_W'(60);
      start_r <= '0;
      speed_r <= SPEED_W'(256);
      red_r   <= COL_W'(255);
      green_r <= '0;
      blue_r  <= '0;
    end else begin
      len_r   <= len_nxt;
      start_r <= start_nxt;
      speed_r <= speed_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  // clamp length into 1..MAX_LEDS
  always_comb begin
    cfg.len   = (len_r == '0) ? LEN_W'(1) :
                (len_r > LEN_W'(MAX_LEDS)) ? LEN_W'(MAX_LEDS) : len_r;
    cfg.start = start_r;
    cfg.speed = speed_r;
    cfg.red   = red_r;
    cfg.green = green_r;
    cfg.blue  = blue_r;
  end

  mlfr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_frame_number (in_frame_number),
    .cmd_push        (cmd_push),
    .cmd_full        (cmd_full),
    .cmd             (cmd_w)
  );

  mlfr_cmd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .full  (cmd_full),
    .wdata (cmd_w),
    .empty (cmd_empty),
    .pop   (cmd_pop),
    .rdata (cmd_r)
  );

  mlfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd_empty         (cmd_empty),
    .cmd_pop           (cmd_pop),
    .cmd               (cmd_r),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_led_index     (out_led_index),
    .out_red_out       (out_red_out),
    .out_green_out     (out_green_out),
    .out_blue_out      (out_blue_out),
    .out_lit           (out_lit),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

// ===== hw/rtl/mlfr_checker.sv =====
// Port-level checks for the moving line falloff renderer, bound to the top level.
// Depends on mlfr_pkg and moving_line_falloff_renderer_core.
module mlfr_checker import mlfr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_full,
  input logic             out_empty,
  input logic             out_pop,
  input logic [IDX_W-1:0] out_led_index,
  input logic [COL_W-1:0] out_red_out,
  input logic [COL_W-1:0] out_green_out,
  input logic [COL_W-1:0] out_blue_out,
  input logic             out_lit,
  input logic             out_last_of_frame
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_unlit_black: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_lit) |-> (out_last_of_frame && (out_led_index == '0) &&
                                  (out_red_out == '0) && (out_green_out == '0) &&
                                  (out_blue_out == '0)))
    else $error("empty-frame beat carries data");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_led_index) &&
                                  $stable(out_red_out) && $stable(out_lit) &&
                                  $stable(out_last_of_frame)))
    else $error("stalled result changed");

endmodule

bind moving_line_falloff_renderer_core mlfr_checker u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_full           (in_full),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_led_index     (out_led_index),
  .out_red_out       (out_red_out),
  .out_green_out     (out_green_out),
  .out_blue_out      (out_blue_out),
  .out_lit           (out_lit),
  .out_last_of_frame (out_last_of_frame)
);
